[design/rqs_pkg.sv]
// Shared types and constants for the ready queue selector.
// No dependencies; every other file imports this package.
package rqs_pkg;

    localparam int TAG_W  = 16;
    localparam int WORK_W = 32;
    localparam int PRIO_W = 16;
    localparam int OCC_W  = 5;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_SJF  = 2'd1;
    localparam logic [1:0] MODE_PRIO = 2'd2;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic [WORK_W-1:0]        work;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    // Picker strobe: a read entry is on the bus, and whether it is entry 0.
    typedef struct packed {
        logic valid;
        logic first;
    } pick_ctl_t;

endpackage

[design/rqs_ifs.sv]
// Valid/ready channel interfaces for the ready queue selector:
// request channel, result channel and mode write channel. Uses rqs_pkg.
interface rqs_in_if import rqs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [TAG_W-1:0]         task_tag;
    logic [WORK_W-1:0]        work_estimate;
    logic signed [PRIO_W-1:0] task_priority;

    modport source (output valid, kind, task_tag, work_estimate, task_priority,
                    input ready);
    modport sink   (input valid, kind, task_tag, work_estimate, task_priority,
                    output ready);
endinterface

interface rqs_out_if import rqs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [TAG_W-1:0]         out_tag;
    logic [WORK_W-1:0]        out_work;
    logic signed [PRIO_W-1:0] out_priority;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, status, out_tag, out_work, out_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, out_tag, out_work, out_priority, occupancy,
                    output ready);
endinterface

interface rqs_cfg_if ();
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[design/ready_queue_selector_core.sv]
// Ready queue selector: an enqueue goes straight from idle to the finish state;
// a dequeue has the read port visit each entry in the scan, then the entries
// behind the pick once more to close the gap. One request at a time; the next
// is taken once the result is in the output register.
// Reset (rst_n, async low) empties the queue and sets the mode to oldest first.
module ready_queue_selector_core import rqs_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rqs_in_if.sink    request,
    rqs_out_if.source result,
    rqs_cfg_if.sink   cfg
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    ctrl_state_t   state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    status_t       status_reg, status_next;
    logic [1:0]    sched_mode_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               out_status_reg, out_status_next;
    logic [TAG_W-1:0]         out_tag_reg, out_tag_next;
    logic [WORK_W-1:0]        out_work_reg, out_work_next;
    logic signed [PRIO_W-1:0] out_prio_reg, out_prio_next;
    logic [OCC_W-1:0]         out_occ_reg, out_occ_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    entry_t        mem_wdata, mem_rdata;
    entry_t        req_entry;
    pick_ctl_t     pick_ctl;
    logic [AW-1:0] sel_idx;
    entry_t        best;

    rqs_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rqs_picker #(.DEPTH(QUEUE_DEPTH)) u_picker (
        .clk     (clk),
        .ctl     (pick_ctl),
        .mode    (sched_mode_reg),
        .idx     (pend_idx_reg),
        .data    (mem_rdata),
        .sel_idx (sel_idx),
        .best    (best)
    );

    assign cfg.ready     = 1'b1;
    assign request.ready = (state_reg == S_IDLE);

    assign req_entry.tag  = request.task_tag;
    assign req_entry.work = request.work_estimate;
    assign req_entry.prio = request.task_priority;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_mode_reg <= MODE_FIFO;
        end
        else if (cfg.valid)
        begin
            sched_mode_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        wr_ptr_reg     <= wr_ptr_next;
        pend_idx_reg   <= pend_idx_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_work_reg   <= out_work_next;
        out_prio_reg   <= out_prio_next;
        out_occ_reg    <= out_occ_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_work_next   = out_work_reg;
        out_prio_next   = out_prio_reg;
        out_occ_next    = out_occ_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_ptr_reg;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = ptr_reg[AW-1:0];
        pick_ctl.valid  = 1'b0;
        pick_ctl.first  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = S_FINISH;
                    if (request.kind == KIND_ENQ)
                    begin
                        if (count_reg == CW'(QUEUE_DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = count_reg[AW-1:0];
                            mem_wdata   = req_entry;
                            count_next  = count_reg + CW'(1);
                            status_next = ST_ENQUEUED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        status_next = ST_DEQUEUED;
                        ptr_next    = '0;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                pick_ctl.valid = pend_reg;
                pick_ctl.first = (pend_idx_reg == '0);
                if (ptr_reg < count_reg)
                begin
                    mem_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg[AW-1:0];
                    ptr_next      = ptr_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    // pick is settled: move everything behind it down by one
                    ptr_next    = CW'(sel_idx) + CW'(1);
                    wr_ptr_next = sel_idx;
                    state_next  = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // read runs two addresses ahead of the write, no overlap
                if (pend_reg)
                begin
                    mem_we      = 1'b1;
                    wr_ptr_next = wr_ptr_reg + AW'(1);
                end
                if (ptr_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    ptr_next  = ptr_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_occ_next    = OCC_W'(count_reg);
                    if (status_reg == ST_DEQUEUED)
                    begin
                        out_tag_next  = best.tag;
                        out_work_next = best.work;
                        out_prio_next = best.prio;
                    end
                    else
                    begin
                        out_tag_next  = '0;
                        out_work_next = '0;
                        out_prio_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.out_tag      = out_tag_reg;
    assign result.out_work     = out_work_reg;
    assign result.out_priority = out_prio_reg;
    assign result.occupancy    = out_occ_reg;

endmodule

[design/rqs_mem.sv]
// Entry store: one write port, one read port, registered read data.
// Uses rqs_pkg for the entry type.
module rqs_mem import rqs_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/rqs_picker.sv]
// Best-entry tracker: compares each scanned entry against the current pick.
// Uses rqs_pkg for entry, strobe and mode codes.
module rqs_picker import rqs_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  pick_ctl_t     ctl,
    input  logic [1:0]    mode,
    input  logic [AW-1:0] idx,
    input  entry_t        data,
    output logic [AW-1:0] sel_idx,
    output entry_t        best
);

    logic [AW-1:0] sel_idx_reg;
    entry_t        best_reg;
    logic          better;

    // strict compares: on a tie the older entry stays
    always_comb
    begin
        case (mode)
            MODE_SJF:  better = data.work < best_reg.work;
            MODE_PRIO: better = data.prio > best_reg.prio;
            default:   better = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid && (ctl.first || better))
        begin
            sel_idx_reg <= idx;
            best_reg    <= data;
        end
    end

    assign sel_idx = sel_idx_reg;
    assign best    = best_reg;

endmodule

[design/rqs_checker.sv]
// Port-level checks for ready_queue_selector_core, attached by bind.
// Uses rqs_pkg status codes.
module rqs_checker import rqs_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [1:0]               status,
    input logic [TAG_W-1:0]         out_tag,
    input logic [WORK_W-1:0]        out_work,
    input logic signed [PRIO_W-1:0] out_priority,
    input logic [OCC_W-1:0]         occupancy
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy))
        else $error("result changed while stalled");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in progress");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> occupancy == '0)
        else $error("empty status with nonzero occupancy");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> occupancy == OCC_W'(QUEUE_DEPTH))
        else $error("full status with occupancy below depth");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DEQUEUED
            |-> out_tag == '0 && out_work == '0 && out_priority == '0)
        else $error("payload not cleared on non-dequeue result");

endmodule

bind ready_queue_selector_core rqs_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rqs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (request.valid),
    .in_ready     (request.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .status       (result.status),
    .out_tag      (result.out_tag),
    .out_work     (result.out_work),
    .out_priority (result.out_priority),
    .occupancy    (result.occupancy)
);

[sim/ready_queue_selector_core_test.sv]
// Self-checking testbench for ready_queue_selector_core: random and directed
// enqueue/dequeue traffic under every selection mode, checked against a predictor.
// Depends on rqs_pkg and the channel interfaces in rqs_ifs.sv.
module ready_queue_selector_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rqs_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [1:0] MODE_SPARE = 2'd3;  // unused encoding, acts as oldest first

    // Ready queue predictor plus the list of results still owed by the block.
    class queue_scoreboard;
        typedef struct packed {
            status_t          status;
            entry_t           ent;
            logic [OCC_W-1:0] occ;
        } outcome_t;

        entry_t     held[$];
        outcome_t   awaited[$];
        logic [1:0] mode;
        int         depth;
        int         errors;
        int         checked;
        int         n_enq;
        int         n_deq;
        int         n_full;
        int         n_empty;

        function new(int depth_i);
            depth   = depth_i;
            mode    = MODE_FIFO;
            errors  = 0;
            checked = 0;
            n_enq   = 0;
            n_deq   = 0;
            n_full  = 0;
            n_empty = 0;
        endfunction

        function void write_mode(logic [1:0] m);
            mode = m;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function int held_count();
            return held.size();
        endfunction

        // Called once per accepted request; works out the result it owes.
        function void note_request(logic kind, entry_t e);
            outcome_t o;
            int       best;
            o = '0;
            if (kind == KIND_ENQ) begin
                if (held.size() >= depth) begin
                    o.status = ST_FULL;
                    n_full++;
                end else begin
                    held.push_back(e);
                    o.status = ST_ENQUEUED;
                    n_enq++;
                end
            end else if (held.size() == 0) begin
                o.status = ST_EMPTY;
                n_empty++;
            end else begin
                best = 0;
                // strict compares, so the oldest entry wins a tie
                for (int i = 1; i < held.size(); i++) begin
                    if (mode == MODE_SJF && held[i].work < held[best].work)
                        best = i;
                    else if (mode == MODE_PRIO && held[i].prio > held[best].prio)
                        best = i;
                end
                o.ent = held[best];
                held.delete(best);
                o.status = ST_DEQUEUED;
                n_deq++;
            end
            o.occ = OCC_W'(held.size());
            awaited.push_back(o);
        endfunction

        function void compare_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] st, logic [TAG_W-1:0] tag,
                                   logic [WORK_W-1:0] work, logic signed [PRIO_W-1:0] prio,
                                   logic [OCC_W-1:0] occ);
            outcome_t o;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d tag %h",
                         $time, st, tag);
                errors++;
                return;
            end
            o = awaited.pop_front();
            checked++;
            compare_field("status", o.status, st);
            compare_field("out_tag", o.ent.tag, tag);
            compare_field("out_work", o.ent.work, work);
            compare_field("out_priority", o.ent.prio, prio);
            compare_field("occupancy", o.occ, occ);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rqs_in_if  req_ch ();
    rqs_out_if res_ch ();
    rqs_cfg_if mode_ch ();

    ready_queue_selector_core #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch),
        .cfg     (mode_ch)
    );

    queue_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold_req    = 0;
    int mode_writes    = 0;
    int requests_sent  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.status, res_ch.out_tag, res_ch.out_work,
                            res_ch.out_priority, res_ch.occupancy);
    end

    // Result-side back pressure; a long hold-off is counted here.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req != 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic entry_t random_entry();
        entry_t e;
        e.tag = TAG_W'($urandom);
        case ($urandom_range(7))
            0, 1, 2: e.work = $urandom;
            3, 4, 5: e.work = $urandom_range(7);  // narrow range to force ties
            6:       e.work = '0;
            default: e.work = '1;
        endcase
        case ($urandom_range(7))
            0, 1, 2: e.prio = PRIO_W'($urandom);
            3, 4, 5: e.prio = PRIO_W'(int'($urandom_range(6)) - 3);
            6:       e.prio = 16'sh8000;
            default: e.prio = 16'sh7fff;
        endcase
        return e;
    endfunction

    // Returns at a falling edge with valid still up, so back-to-back requests
    // never see valid dropped and raised in one step.
    task automatic send_request(input logic kind, input entry_t e);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= kind;
        req_ch.task_tag      <= e.tag;
        req_ch.work_estimate <= e.work;
        req_ch.task_priority <= e.prio;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(kind, e);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        drain();
        mode_ch.valid <= 1'b1;
        mode_ch.data  <= m;
        @(posedge clk);
        while (!mode_ch.ready)
            @(posedge clk);
        sb.write_mode(m);
        mode_writes++;
        @(negedge clk);
        mode_ch.valid <= 1'b0;
    endtask

    initial
    begin
        entry_t     e;
        logic       kind;
        bit         filling;
        logic [1:0] m;

        sb = new(DEPTH);
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = KIND_ENQ;
        req_ch.task_tag      = '0;
        req_ch.work_estimate = '0;
        req_ch.task_priority = '0;
        res_ch.ready         = 1'b0;
        mode_ch.valid        = 1'b0;
        mode_ch.data         = MODE_FIFO;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty dequeue, fill to capacity with extremes and ties,
        // reject when full, then at least one pick per mode
        send_request(KIND_DEQ, random_entry());
        for (int i = 0; i < DEPTH; i++)
        begin
            e.tag  = (i == DEPTH - 1) ? 16'hffff : TAG_W'(i * 16'h0101);
            e.work = (i == 0) ? 32'hffff_ffff : (i == 3 || i == 7) ? 32'd0 : 32'd1000 + i;
            e.prio = (i == 5 || i == 9) ? 16'sh7fff :
                     (i == 2) ? 16'sh8000 : PRIO_W'(i - 8);
            send_request(KIND_ENQ, e);
        end
        send_request(KIND_ENQ, random_entry());
        write_mode(MODE_SJF);
        send_request(KIND_DEQ, random_entry());
        send_request(KIND_DEQ, random_entry());
        write_mode(MODE_PRIO);
        send_request(KIND_DEQ, random_entry());
        send_request(KIND_DEQ, random_entry());
        write_mode(MODE_SPARE);
        send_request(KIND_DEQ, random_entry());
        write_mode(MODE_FIFO);
        send_request(KIND_DEQ, random_entry());

        filling = 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0, 6:    m = MODE_FIFO;
                1, 5:    m = MODE_SJF;
                3:       m = MODE_SPARE;
                default: m = MODE_PRIO;
            endcase
            write_mode(m);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int n = 0; n < 128; n++)
            begin
                if (ph == 0 && n == 40)
                    rx_hold_req = 300;
                if (ph == 5 && n == 64)
                    drain();
                // swing between filling and emptying so full and empty both occur
                if (sb.held_count() == DEPTH && $urandom_range(3) == 0)
                    filling = 1'b0;
                else if (sb.held_count() == 0 && $urandom_range(2) == 0)
                    filling = 1'b1;
                else if ($urandom_range(24) == 0)
                    filling = !filling;
                if (filling)
                    kind = ($urandom_range(99) < 25) ? KIND_DEQ : KIND_ENQ;
                else
                    kind = ($urandom_range(99) < 25) ? KIND_ENQ : KIND_DEQ;
                send_request(kind, random_entry());
            end
        end

        drain();
        repeat (40) @(negedge clk);
        $display("Covered %0d requests over %0d mode writes: %0d enqueued, %0d dequeued,",
                 requests_sent, mode_writes, sb.n_enq, sb.n_deq);
        $display("%0d rejected as full, %0d empty dequeues; %0d results checked, %0d errors.",
                 sb.n_full, sb.n_empty, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

[ready_queue_selector_core.f]
design/rqs_pkg.sv
design/rqs_ifs.sv
design/rqs_mem.sv
design/rqs_picker.sv
design/ready_queue_selector_core.sv
design/rqs_checker.sv
sim/ready_queue_selector_core_test.sv
